>>> rtl/core/atp_pkg.sv
// Shared types, character codes and keyword tables of the age text parser.
`timescale 1ns / 1ps
`default_nettype none

package atp_pkg;

    // Default width of one decimal number; values above 2^VALUE_BITS - 1 are out of range.
    localparam int VALUE_BITS_DEF = 31;

    // Result payload width: kind, modifier, three counts and the error code.
    localparam int RESULT_BITS = 104;

    // Character codes.
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_D     = 8'h44;

    // Parser phases, one-hot.
    typedef enum logic [7:0] {
        PH_START = 8'b0000_0001,
        PH_MODSP = 8'b0000_0010,
        PH_NUM   = 8'b0000_0100,
        PH_UNIT  = 8'b0000_1000,
        PH_WS    = 8'b0001_0000,
        PH_SIGN  = 8'b0010_0000,
        PH_WORD  = 8'b0100_0000,
        PH_STOP  = 8'b1000_0000
    } t_phase;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_NUMERIC   = 3'd1,
        KIND_CHILD     = 3'd2,
        KIND_INFANT    = 3'd3,
        KIND_STILLBORN = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MOD_NONE = 2'd0,
        MOD_LESS = 2'd1,
        MOD_MORE = 2'd2
    } t_mod;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_RANGE     = 3'd1,
        ERR_DUP_UNIT  = 3'd2,
        ERR_BAD_UNIT  = 3'd3,
        ERR_BAD_FORM  = 3'd4
    } t_err;

    // One result; the first member sits in the highest bits.
    typedef struct packed {
        t_err        err_code;
        logic [31:0] day_count;
        logic [31:0] month_count;
        logic [31:0] year_count;
        t_mod        modifier;
        t_kind       age_kind;
    } t_result;

    // Keywords, upper case, padded with zeros to sixteen positions.
    localparam logic [7:0] KW_TXT [3][16] = '{
        '{"C", "H", "I", "L", "D", 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"I", "N", "F", "A", "N", "T", 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "I", "L", "L", "B", "O", "R",
          "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [3] = '{4'd5, 4'd6, 4'd9};

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_wspace(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'h20) : b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/age_text_parser.sv
// Top level of the age text parser: byte-wise parse state and a two-deep result buffer.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                     Contents
// s_axis    in         tvalid/tready/tdata/tlast   tdata[7:0] text_byte, tlast end_mark
// m_axis    out        tvalid/tready/tdata         one result per text, see tdata below
//
// Every request is handled in the cycle it is accepted, so a new byte can be taken on
// every clock; the parse state registers are updated by one short step of logic per
// byte, the widest part being the times-ten add of the number accumulator.
// The result of an end request is written into an output register, backed by a
// skid register, so the input side keeps running while the output side stalls.
// The input stalls only while both of those registers hold results.
// The synchronous, active-low reset returns the parser to the start of a text and
// empties both result registers.
module age_text_parser
    import atp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire  [7:0]             i_s_axis_tdata,  // [7:0] text_byte
    input  wire                    i_s_axis_tlast,  // end_mark
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    // [2:0] age_kind, [4:3] modifier, [36:5] year_count, [68:37] month_count,
    // [100:69] day_count, [103:101] error_code
    output logic [RESULT_BITS-1:0] o_m_axis_tdata
);

    localparam int PW = VALUE_BITS + 4;

    // Parse state.
    t_phase                r_phase, n_phase;
    t_mod                  r_mod, n_mod;
    t_err                  r_err, n_err;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_ovf, n_ovf;
    logic [VALUE_BITS-1:0] r_year_val, n_year_val;
    logic [VALUE_BITS-1:0] r_month_val, n_month_val;
    logic [VALUE_BITS-1:0] r_day_val, n_day_val;
    logic                  r_year_ok, n_year_ok;
    logic                  r_month_ok, n_month_ok;
    logic                  r_day_ok, n_day_ok;
    logic [2:0]            r_alive, n_alive;
    logic [3:0]            r_pos, n_pos;

    // Result buffer.
    t_result               r_out, n_out;
    t_result               r_skid, n_skid;
    logic                  r_out_valid, n_out_valid;
    logic                  r_skid_valid, n_skid_valid;

    logic                  s_acc;
    logic                  m_take;
    logic                  res_load;
    t_result               res;

    logic [7:0]            b;
    logic [7:0]            ub;
    logic [3:0]            dval;
    logic [VALUE_BITS-1:0] acc_base;
    logic [PW-1:0]         prod;
    logic                  prod_ovf;
    logic                  hit_y, hit_m, hit_d, unit_hit, unit_dup;
    logic [VALUE_BITS-1:0] unit_val;
    logic [2:0]            kw_hit;
    logic                  num_bad;

    assign o_s_axis_tready = !r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign m_take   = r_out_valid && i_m_axis_tready;
    assign res_load = s_acc && i_s_axis_tlast;

    assign b    = i_s_axis_tdata;
    assign ub   = to_upper(b);
    assign dval = b[3:0];

    // Next number value: digits extend the running number only while inside one.
    assign acc_base = (r_phase == PH_NUM) ? r_acc : '0;
    assign prod     = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} + PW'(dval);
    assign prod_ovf = |prod[PW-1:VALUE_BITS];

    assign hit_y    = (ub == CH_Y);
    assign hit_m    = (ub == CH_M);
    assign hit_d    = (ub == CH_D);
    assign unit_hit = hit_y || hit_m || hit_d;
    assign unit_dup = (hit_y && r_year_ok) || (hit_m && r_month_ok) || (hit_d && r_day_ok);
    // A unit letter right after a unit carries no digits and counts as zero.
    assign unit_val = (r_phase == PH_NUM) ? r_acc : '0;

    // A negative sign is only allowed in front of a zero.
    assign num_bad = r_ovf || (r_neg && (r_acc != '0));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            kw_hit[k] = r_alive[k] && (r_pos < KW_LEN[k]) && (ub == KW_TXT[k][r_pos]);
        end
    end

    // Result of an end request, taken from the state left by the bytes before it.
    always_comb begin
        res.age_kind    = KIND_NONE;
        res.err_code    = r_err;
        res.modifier    = r_mod;
        res.year_count  = r_year_ok  ? 32'(r_year_val)  : '1;
        res.month_count = r_month_ok ? 32'(r_month_val) : '1;
        res.day_count   = r_day_ok   ? 32'(r_day_val)   : '1;
        unique case (r_phase)
            PH_START, PH_MODSP, PH_WORD: begin
                if (r_alive[0] && (r_pos == KW_LEN[0])) begin
                    res.age_kind = KIND_CHILD;
                end else if (r_alive[1] && (r_pos == KW_LEN[1])) begin
                    res.age_kind = KIND_INFANT;
                end else if (r_alive[2] && (r_pos == KW_LEN[2])) begin
                    res.age_kind = KIND_STILLBORN;
                end else begin
                    res.err_code = ERR_BAD_FORM;
                end
            end
            PH_NUM: begin
                if (num_bad) begin
                    res.err_code = ERR_RANGE;
                end else begin
                    res.age_kind = KIND_NUMERIC;
                end
            end
            PH_UNIT: begin
                res.age_kind = KIND_NUMERIC;
            end
            PH_WS, PH_SIGN: begin
                res.err_code = ERR_BAD_UNIT;
            end
            PH_STOP: begin
            end
            default: begin
            end
        endcase
        if (res.err_code != ERR_OK) begin
            res.age_kind = KIND_NONE;
        end
    end

    // Parse state update for one byte, or back to the start on an end request.
    always_comb begin
        n_phase     = r_phase;
        n_mod       = r_mod;
        n_err       = r_err;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_ovf       = r_ovf;
        n_year_val  = r_year_val;
        n_month_val = r_month_val;
        n_day_val   = r_day_val;
        n_year_ok   = r_year_ok;
        n_month_ok  = r_month_ok;
        n_day_ok    = r_day_ok;
        n_alive     = r_alive;
        n_pos       = r_pos;

        if (s_acc && i_s_axis_tlast) begin
            n_phase    = PH_START;
            n_mod      = MOD_NONE;
            n_err      = ERR_OK;
            n_acc      = '0;
            n_neg      = 1'b0;
            n_ovf      = 1'b0;
            n_year_ok  = 1'b0;
            n_month_ok = 1'b0;
            n_day_ok   = 1'b0;
            n_alive    = 3'b111;
            n_pos      = '0;
        end else if (s_acc) begin
            unique case (r_phase)
                PH_START: begin
                    if ((b == CH_LT) || (b == CH_GT)) begin
                        n_mod   = (b == CH_LT) ? MOD_LESS : MOD_MORE;
                        n_alive = '0;
                        n_phase = PH_MODSP;
                    end else if (is_digit(b)) begin
                        n_acc   = prod[VALUE_BITS-1:0];
                        n_ovf   = prod_ovf;
                        n_neg   = 1'b0;
                        n_phase = PH_NUM;
                    end else begin
                        n_alive = kw_hit;
                        n_pos   = (r_pos == 4'hF) ? r_pos : r_pos + 4'd1;
                        n_phase = PH_WORD;
                    end
                end
                PH_MODSP: begin
                    if (is_digit(b)) begin
                        n_acc   = prod[VALUE_BITS-1:0];
                        n_ovf   = prod_ovf;
                        n_neg   = 1'b0;
                        n_phase = PH_NUM;
                    end else if (b != CH_SPACE) begin
                        n_phase = PH_WORD;
                    end
                end
                PH_WORD: begin
                    n_alive = kw_hit;
                    n_pos   = (r_pos == 4'hF) ? r_pos : r_pos + 4'd1;
                end
                PH_NUM: begin
                    if (is_digit(b)) begin
                        n_acc = prod[VALUE_BITS-1:0];
                        n_ovf = r_ovf || prod_ovf;
                    end else if (num_bad) begin
                        n_err   = ERR_RANGE;
                        n_phase = PH_STOP;
                    end else if (!unit_hit) begin
                        n_err   = ERR_BAD_UNIT;
                        n_phase = PH_STOP;
                    end else if (unit_dup) begin
                        n_err   = ERR_DUP_UNIT;
                        n_phase = PH_STOP;
                    end else begin
                        n_year_ok   = r_year_ok || hit_y;
                        n_month_ok  = r_month_ok || hit_m;
                        n_day_ok    = r_day_ok || hit_d;
                        n_year_val  = hit_y ? unit_val : r_year_val;
                        n_month_val = hit_m ? unit_val : r_month_val;
                        n_day_val   = hit_d ? unit_val : r_day_val;
                        n_phase     = PH_UNIT;
                    end
                end
                PH_UNIT: begin
                    if (b == CH_SPACE) begin
                        n_phase = PH_UNIT;
                    end else if (is_digit(b)) begin
                        n_acc   = prod[VALUE_BITS-1:0];
                        n_ovf   = prod_ovf;
                        n_neg   = 1'b0;
                        n_phase = PH_NUM;
                    end else if (is_wspace(b)) begin
                        n_acc   = '0;
                        n_neg   = 1'b0;
                        n_ovf   = 1'b0;
                        n_phase = PH_WS;
                    end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
                        n_acc   = '0;
                        n_neg   = (b == CH_MINUS);
                        n_ovf   = 1'b0;
                        n_phase = PH_SIGN;
                    end else begin
                        n_acc = '0;
                        n_neg = 1'b0;
                        n_ovf = 1'b0;
                        if (!unit_hit) begin
                            n_err   = ERR_BAD_UNIT;
                            n_phase = PH_STOP;
                        end else if (unit_dup) begin
                            n_err   = ERR_DUP_UNIT;
                            n_phase = PH_STOP;
                        end else begin
                            n_year_ok   = r_year_ok || hit_y;
                            n_month_ok  = r_month_ok || hit_m;
                            n_day_ok    = r_day_ok || hit_d;
                            n_year_val  = hit_y ? unit_val : r_year_val;
                            n_month_val = hit_m ? unit_val : r_month_val;
                            n_day_val   = hit_d ? unit_val : r_day_val;
                            n_phase     = PH_UNIT;
                        end
                    end
                end
                PH_WS: begin
                    if (is_wspace(b)) begin
                        n_phase = PH_WS;
                    end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
                        n_neg   = (b == CH_MINUS);
                        n_phase = PH_SIGN;
                    end else if (is_digit(b)) begin
                        n_acc   = prod[VALUE_BITS-1:0];
                        n_ovf   = prod_ovf;
                        n_phase = PH_NUM;
                    end else begin
                        n_err   = ERR_BAD_UNIT;
                        n_phase = PH_STOP;
                    end
                end
                PH_SIGN: begin
                    if (is_digit(b)) begin
                        n_acc   = prod[VALUE_BITS-1:0];
                        n_ovf   = prod_ovf;
                        n_phase = PH_NUM;
                    end else begin
                        n_err   = ERR_BAD_UNIT;
                        n_phase = PH_STOP;
                    end
                end
                PH_STOP: begin
                    n_phase = PH_STOP;
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
        end
    end

    // Output register with a skid register behind it.
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || m_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = res_load;
            end
        end else if (res_load) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_mod        <= MOD_NONE;
            r_err        <= ERR_OK;
            r_neg        <= 1'b0;
            r_ovf        <= 1'b0;
            r_year_ok    <= 1'b0;
            r_month_ok   <= 1'b0;
            r_day_ok     <= 1'b0;
            r_alive      <= 3'b111;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_mod        <= n_mod;
            r_err        <= n_err;
            r_neg        <= n_neg;
            r_ovf        <= n_ovf;
            r_year_ok    <= n_year_ok;
            r_month_ok   <= n_month_ok;
            r_day_ok     <= n_day_ok;
            r_alive      <= n_alive;
            r_pos        <= n_pos;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_year_val  <= n_year_val;
        r_month_val <= n_month_val;
        r_day_val   <= n_day_val;
        r_out       <= n_out;
        r_skid      <= n_skid;
    end

    // The skid register only fills behind a held output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    // A reported error always comes with an unrecognized kind.
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.err_code != ERR_OK)) |-> (r_out.age_kind == KIND_NONE))
        else $error("result carries an error together with a recognized kind");

    // An end request always returns the parser to the start of a text.
    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_axis_tlast) |=> ((r_phase == PH_START) && (r_err == ERR_OK)))
        else $error("parser did not restart after an end request");

    // A stored error always freezes the parse.
    a_err_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_OK) |-> (r_phase == PH_STOP))
        else $error("error stored while the parser keeps running");

endmodule

`default_nettype wire

>>> sim/age_parse_checker.sv
// Checker of the age text parser: predicts each result from the accepted bytes and compares.
`timescale 1ns / 1ps

module age_parse_checker
    import atp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [7:0]             i_s_tdata,
    input  logic                   i_s_tlast,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [RESULT_BITS-1:0] i_m_tdata,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam logic [63:0] NUM_LIMIT = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [31:0] ABSENT    = 32'hFFFF_FFFF;
    localparam t_kind       KW_KIND [3] = '{KIND_CHILD, KIND_INFANT, KIND_STILLBORN};

    string kw_names [3] = '{"CHILD", "INFANT", "STILLBORN"};

    // Predicted parse state.
    t_phase      ph;
    t_mod        mod_q;
    logic [63:0] acc;
    logic        acc_neg;
    logic        acc_ovf;
    logic [31:0] counts [3];   // years, months, days
    logic [2:0]  kw_alive;
    logic [3:0]  kw_pos;
    t_err        err_q;

    t_result expected_ages [$];
    t_result want;
    t_result got;

    function automatic bit digit_char(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic bit space_like(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        if ((b >= 8'h61) && (b <= 8'h7A)) return b - 8'h20;
        return b;
    endfunction

    function automatic int unit_slot(input logic [7:0] b);
        logic [7:0] u;
        u = fold_case(b);
        if (u == CH_Y) return 0;
        if (u == CH_M) return 1;
        if (u == CH_D) return 2;
        return -1;
    endfunction

    task automatic zero_number();
        acc     = 64'd0;
        acc_neg = 1'b0;
        acc_ovf = 1'b0;
    endtask

    task automatic clear_parse();
        ph       = PH_START;
        mod_q    = MOD_NONE;
        zero_number();
        counts   = '{ABSENT, ABSENT, ABSENT};
        kw_alive = 3'b111;
        kw_pos   = 4'd0;
        err_q    = ERR_OK;
    endtask

    task automatic raise(input t_err code);
        err_q = code;
        ph    = PH_STOP;
    endtask

    // Once the value would pass the limit it stays flagged and stops growing.
    task automatic push_digit(input logic [7:0] b);
        logic [63:0] d;
        d = 64'(b - 8'h30);
        if (!acc_ovf) begin
            if (acc > (NUM_LIMIT - d) / 64'd10) acc_ovf = 1'b1;
            else acc = acc * 64'd10 + d;
        end
    endtask

    task automatic open_number(input logic [7:0] b);
        zero_number();
        push_digit(b);
        ph = PH_NUM;
    endtask

    task automatic range_ok(output bit ok);
        if (acc_ovf || (acc_neg && acc != 64'd0)) begin
            raise(ERR_RANGE);
            ok = 1'b0;
        end else begin
            ok = 1'b1;
        end
    endtask

    task automatic store_unit(input int slot);
        if (counts[slot] != ABSENT) begin
            raise(ERR_DUP_UNIT);
        end else begin
            counts[slot] = acc[31:0];
            ph = PH_UNIT;
        end
    endtask

    task automatic match_keyword(input logic [7:0] b);
        logic [7:0] u;
        u = fold_case(b);
        for (int k = 0; k < 3; k++) begin
            if (kw_alive[k]) begin
                if (kw_pos >= kw_names[k].len() || u != kw_names[k][kw_pos]) kw_alive[k] = 1'b0;
            end
        end
        if (kw_pos < 4'd15) kw_pos = kw_pos + 4'd1;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        bit    ok;
        int    slot;
        t_kind kind;
        t_result res;
        if (last) begin
            kind = KIND_NONE;
            case (ph)
                PH_START, PH_MODSP, PH_WORD: begin
                    for (int k = 0; k < 3; k++) begin
                        if (kw_alive[k] && kw_pos == kw_names[k].len()) kind = KW_KIND[k];
                    end
                    if (kind == KIND_NONE) err_q = ERR_BAD_FORM;
                end
                PH_NUM: begin
                    range_ok(ok);
                    if (ok) kind = KIND_NUMERIC;
                end
                PH_UNIT: kind = KIND_NUMERIC;
                PH_WS, PH_SIGN: err_q = ERR_BAD_UNIT;
                default: ;
            endcase
            if (err_q != ERR_OK) kind = KIND_NONE;
            res.err_code    = err_q;
            res.day_count   = counts[2];
            res.month_count = counts[1];
            res.year_count  = counts[0];
            res.modifier    = mod_q;
            res.age_kind    = kind;
            expected_ages.push_back(res);
            clear_parse();
        end else begin
            case (ph)
                PH_START: begin
                    if (b == CH_LT || b == CH_GT) begin
                        mod_q    = (b == CH_LT) ? MOD_LESS : MOD_MORE;
                        kw_alive = 3'b000;
                        ph       = PH_MODSP;
                    end else if (digit_char(b)) begin
                        open_number(b);
                    end else begin
                        match_keyword(b);
                        ph = PH_WORD;
                    end
                end
                PH_MODSP: begin
                    if (digit_char(b)) open_number(b);
                    else if (b != CH_SPACE) ph = PH_WORD;
                end
                PH_WORD: match_keyword(b);
                PH_NUM: begin
                    if (digit_char(b)) begin
                        push_digit(b);
                    end else begin
                        range_ok(ok);
                        if (ok) begin
                            slot = unit_slot(b);
                            if (slot < 0) raise(ERR_BAD_UNIT);
                            else store_unit(slot);
                        end
                    end
                end
                PH_UNIT: begin
                    if (b == CH_SPACE) begin
                        // Spaces after a unit are skipped.
                    end else if (digit_char(b)) begin
                        open_number(b);
                    end else if (space_like(b)) begin
                        zero_number();
                        ph = PH_WS;
                    end else if (b == CH_PLUS || b == CH_MINUS) begin
                        zero_number();
                        acc_neg = (b == CH_MINUS);
                        ph = PH_SIGN;
                    end else begin
                        // A unit with no digits before it stores zero.
                        slot = unit_slot(b);
                        zero_number();
                        if (slot < 0) raise(ERR_BAD_UNIT);
                        else store_unit(slot);
                    end
                end
                PH_WS: begin
                    if (space_like(b)) begin
                        // Further white space between units.
                    end else if (b == CH_PLUS || b == CH_MINUS) begin
                        acc_neg = (b == CH_MINUS);
                        ph = PH_SIGN;
                    end else if (digit_char(b)) begin
                        push_digit(b);
                        ph = PH_NUM;
                    end else begin
                        raise(ERR_BAD_UNIT);
                    end
                end
                PH_SIGN: begin
                    if (digit_char(b)) begin
                        push_digit(b);
                        ph = PH_NUM;
                    end else begin
                        raise(ERR_BAD_UNIT);
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic signed [63:0] exp_v,
                               input logic signed [63:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    // Results are matched before the new byte is parsed, so a result can never
    // be paired with an expectation pushed in the same cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            expected_ages.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata);
                if (expected_ages.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, i_m_tdata);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_ages.pop_front();
                    check_field("age_kind", 64'(want.age_kind), 64'(got.age_kind));
                    check_field("modifier", 64'(want.modifier), 64'(got.modifier));
                    check_field("year_count", $signed(want.year_count), $signed(got.year_count));
                    check_field("month_count", $signed(want.month_count),
                                $signed(got.month_count));
                    check_field("day_count", $signed(want.day_count), $signed(got.day_count));
                    check_field("error_code", 64'(want.err_code), 64'(got.err_code));
                end
            end
            if (i_s_tvalid && i_s_tready) parse_byte(i_s_tdata, i_s_tlast);
        end
        o_pending = expected_ages.size();
    end

endmodule

>>> sim/testbench.sv
// Testbench top of the age text parser: clock, reset, text stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import atp_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic [7:0]             s_tdata;
    logic                   s_tlast;
    logic                   m_tready;
    wire                    s_tready;
    wire                    m_tvalid;
    wire  [RESULT_BITS-1:0] m_tdata;

    int fail_count;
    int n_pending;

    // Bytes of the text being built, the count of byte requests sent so far,
    // and whether the sender currently runs without gaps.
    logic [7:0] text_q [$];
    int         sent_items;
    bit         quiet;

    string kw_names [3] = '{"CHILD", "INFANT", "STILLBORN"};

    age_text_parser u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    age_parse_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (n_pending)
    );

    // 20 ns period, starting low.
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // All inputs change on the falling edge; the block and the checker see
    // them settled at the next rising edge.
    task automatic send_item(input logic [7:0] b, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        sent_items++;
    endtask

    task automatic load(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // The end request carries a random byte, which the block must ignore.
    task automatic send_text();
        foreach (text_q[i]) send_item(text_q[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        text_q.delete();
    endtask

    // Drops the valid line and waits until every predicted result has come.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (n_pending == 0);
    endtask

    // Most texts are well formed, numeric or keyword, with random content;
    // the rest are random bytes, and a few texts get one byte overwritten.
    task automatic build_random_text();
        int         kind_sel;
        int         parts;
        int         p;
        int         n;
        int         k;
        int         j;
        int         tmp;
        int         slots [3];
        bit         has_unit;
        logic [7:0] c;
        string      word;
        if ($urandom_range(0, 9) == 0) begin
            text_q.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
            repeat ($urandom_range(0, 2)) text_q.push_back(CH_SPACE);
        end
        kind_sel = $urandom_range(0, 99);
        if (kind_sel < 60) begin
            // Units come in a shuffled order so that duplicates stay occasional.
            slots = '{0, 1, 2};
            for (int i = 2; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = slots[i];
                slots[i] = slots[j];
                slots[j] = tmp;
            end
            parts = $urandom_range(1, 4);
            for (int i = 0; i < parts; i++) begin
                if (i > 0) begin
                    p = $urandom_range(0, 11);
                    if (p == 0) begin
                        repeat ($urandom_range(1, 2)) text_q.push_back(8'($urandom_range(9, 13)));
                    end else if (p == 1) begin
                        text_q.push_back(CH_PLUS);
                    end else if (p == 2) begin
                        text_q.push_back(CH_MINUS);
                    end else if (p == 3) begin
                        text_q.push_back(8'h09);
                        text_q.push_back(CH_MINUS);
                    end
                end
                p = $urandom_range(0, 19);
                if (p == 0 && i > 0) begin
                    n = 0;
                end else if (p == 1) begin
                    load($urandom_range(0, 1) ? "2147483647" : "2147483648");
                    n = 0;
                end else begin
                    n = (p == 2) ? $urandom_range(10, 12) : $urandom_range(1, 3);
                end
                repeat (n) text_q.push_back(8'($urandom_range(48, 57)));
                p = $urandom_range(0, 24);
                has_unit = 1'b1;
                if (p == 0) begin
                    text_q.push_back(8'($urandom_range(33, 126)));
                end else if (p == 1 && i == parts - 1) begin
                    has_unit = 1'b0;   // trailing number without a unit
                end else begin
                    k = (i < 3) ? slots[i] : $urandom_range(0, 2);
                    c = (k == 0) ? CH_Y : ((k == 1) ? CH_M : CH_D);
                    if ($urandom_range(0, 1)) c = c + 8'h20;
                    text_q.push_back(c);
                end
                if (has_unit) repeat ($urandom_range(0, 2)) text_q.push_back(CH_SPACE);
            end
        end else if (kind_sel < 85) begin
            k = $urandom_range(0, 2);
            word = kw_names[k];
            p = $urandom_range(0, 9);
            if (p == 0) word = word.substr(0, word.len() - 2);
            else if (p == 1) word = {word, "S"};
            for (int i = 0; i < word.len(); i++) begin
                c = word[i];
                if ($urandom_range(0, 1)) c = c + 8'h20;
                text_q.push_back(c);
            end
        end else begin
            repeat ($urandom_range(0, 12)) text_q.push_back(8'($urandom_range(0, 255)));
        end
        if (text_q.size() > 0 && $urandom_range(0, 19) == 0) begin
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    // Result side: a random stall before each result, runs without stalls
    // now and then, and one long hold-off that fills the result buffer and
    // backs up the byte input while the sender keeps offering requests.
    initial begin : result_side
        int  stall;
        int  taken;
        bit  rx_quiet;
        m_tready = 1'b0;
        taken    = 0;
        rx_quiet = 1'b0;
        wait (rst_n);
        forever begin
            if (taken % 16 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
            if (taken == 30) stall = 600;
            else stall = rx_quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    // Stimulus and verdict.
    initial begin : byte_side
        int    texts;
        string directed [20];
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        sent_items = 0;
        quiet      = 1'b0;
        directed = '{
            "", "child", "INFANT", "sTiLlBoRn", "<Child", "> 2y 3M4d", "1y m",
            "2147483647D", "2147483648y", "99999999999", "1y2Y", "5x", "3y 7",
            "1y \t\015 +2m", "1y -3d", "1y -0d", "1y +", "6m\t", "stillbornstillborn", "<  "
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed texts: keywords in mixed case, the modifiers, the number
        // limit and one past it, duplicate and bad units, a unit with no
        // digits, a trailing number, signed separators and a dangling one,
        // an over-long word, and a zero byte after a number.
        foreach (directed[i]) begin
            load(directed[i]);
            send_text();
        end
        load("7");
        text_q.push_back(8'h00);
        send_text();

        // Random texts; partway through, the sender waits for all results.
        texts = 0;
        while (sent_items < 1650) begin
            if (texts % 12 == 0) quiet = ($urandom_range(0, 2) == 0);
            if (texts == 60) drain();
            build_random_text();
            send_text();
            texts++;
        end

        drain();
        // Results leave through a register stage; a final wait catches
        // anything the block sends without a matching request.
        repeat (20) @(posedge clk);
        if (fail_count == 0 && n_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Safety net: far beyond the slowest correct run.
    initial begin : watchdog
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/atp_pkg.sv
rtl/core/age_text_parser.sv
sim/age_parse_checker.sv
sim/testbench.sv
